### rtl/core/sfta_pkg.sv
// Shared types and codes for the strip and fan triangle assembly block.
package sfta_pkg;

    localparam int unsigned WordWidth   = 16;
    localparam int unsigned IndexWidth  = 15;
    localparam int unsigned Corners     = 3;
    localparam int unsigned QueueDepth  = 2;

    // List mode codes.
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_STRIP  = 2'd1;
    localparam logic [1:0] MODE_FAN    = 2'd2;

    // Record word positions.
    localparam logic [1:0] POS_LAST = 2'd3;

    // Corner index within a triangle.
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd2;

    typedef struct packed {
        logic [IndexWidth-1:0]        vertex_index;
        logic [IndexWidth-1:0]        normal_index;
        logic signed [WordWidth-1:0]  tex_s;
        logic signed [WordWidth-1:0]  tex_t;
    } corner_t;

    typedef corner_t [Corners-1:0] triangle_t;

    // Handshake between the triangle queue and its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/core/strip_fan_triangle_assembly_core.sv
// Top level of the strip and fan triangle assembly block.
//
// Input channel: one signed 16-bit command word per beat (push / full). A
// header word gives a vertex count: positive for a strip, negative for a fan,
// zero to end a mesh's list. Each vertex follows as four words: vertex index,
// normal index, s and t.
// Result channel: one triangle corner per beat (empty / pop). Every triangle
// leaves as three corners; last_corner marks the third one.
// Throughput: one word per cycle while full is low; a triangle's three corners
// leave at one per cycle while the receiver pops, so a triangle (at most one
// per four words) then never limits the input. A triangle's corners become
// visible after it is written into the queue and loaded into the output stage.
// A two-entry triangle queue sits between the parser and the output stage;
// full rises only when both entries hold triangles, then words wait until
// the receiver pops corners. No results are lost while the receiver stalls.
// Reset clears the parser to expect a header and empties the queue and the
// output stage; no clearing pass is needed.
module strip_fan_triangle_assembly_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [sfta_pkg::WordWidth-1:0] word,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [sfta_pkg::IndexWidth-1:0]       vertex_index,
    output logic [sfta_pkg::IndexWidth-1:0]       normal_index,
    output logic signed [sfta_pkg::WordWidth-1:0] tex_s,
    output logic signed [sfta_pkg::WordWidth-1:0] tex_t,
    output logic                                  last_corner
);

    sfta_pkg::queue_status_t q_status;
    sfta_pkg::triangle_t     push_tri;
    sfta_pkg::triangle_t     head_tri;
    sfta_pkg::corner_t       corner;
    logic                    accept;
    logic                    tri_push;
    logic                    q_pop;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    sfta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .word     (word),
        .tri_push (tri_push),
        .tri_data (push_tri)
    );

    sfta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tri_push),
        .push_data (push_tri),
        .pop       (q_pop),
        .pop_data  (head_tri),
        .status    (q_status)
    );

    sfta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (head_tri),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .corner      (corner),
        .last_corner (last_corner)
    );

    assign vertex_index = corner.vertex_index;
    assign normal_index = corner.normal_index;
    assign tex_s        = corner.tex_s;
    assign tex_t        = corner.tex_t;

endmodule

### rtl/core/sfta_front.sv
// Front part: parses command words, rotates corner slots and forms triangles.
module sfta_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic signed [sfta_pkg::WordWidth-1:0] word,
    output logic                                tri_push,
    output sfta_pkg::triangle_t                 tri_data
);

    logic [1:0]                        mode_reg, mode_next;
    logic [sfta_pkg::WordWidth-1:0]    remaining_reg, remaining_next;
    logic [sfta_pkg::WordWidth-1:0]    ordinal_reg, ordinal_next;
    logic [1:0]                        pos_reg, pos_next;
    logic [sfta_pkg::WordWidth-1:0]    partial_reg [0:2];
    sfta_pkg::corner_t [2:0]           slots_reg;
    sfta_pkg::corner_t [2:0]           slots_next;
    sfta_pkg::corner_t                 rec;
    logic [sfta_pkg::WordWidth-1:0]    word_u;
    logic                              partial_we;
    logic                              record_done;
    logic                              rotated;

    assign word_u = word;

    always_comb
    begin
        rec.vertex_index = partial_reg[0][sfta_pkg::IndexWidth-1:0];
        rec.normal_index = partial_reg[1][sfta_pkg::IndexWidth-1:0];
        rec.tex_s        = partial_reg[2];
        rec.tex_t        = word;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        ordinal_next   = ordinal_reg;
        pos_next       = pos_reg;
        slots_next     = slots_reg;
        partial_we     = 1'b0;
        record_done    = 1'b0;
        tri_push       = 1'b0;
        rotated        = 1'b0;
        if (accept)
        begin
            unique case (mode_reg) inside
                sfta_pkg::MODE_HEADER:
                begin
                    if (word_u != '0)
                    begin
                        mode_next      = word_u[sfta_pkg::WordWidth-1] ?
                                         sfta_pkg::MODE_FAN : sfta_pkg::MODE_STRIP;
                        remaining_next = word_u[sfta_pkg::WordWidth-1] ?
                                         (~word_u + 16'd1) : word_u;
                        ordinal_next   = '0;
                        pos_next       = '0;
                    end
                end
                sfta_pkg::MODE_STRIP, sfta_pkg::MODE_FAN:
                begin
                    if (pos_reg != sfta_pkg::POS_LAST)
                    begin
                        partial_we = 1'b1;
                        pos_next   = pos_reg + 2'd1;
                    end
                    else
                    begin
                        record_done = 1'b1;
                        pos_next    = '0;
                        if (ordinal_reg == 16'd0)
                        begin
                            slots_next[0] = rec;
                        end
                        else if (ordinal_reg == 16'd1)
                        begin
                            slots_next[2] = rec;
                        end
                        else if (ordinal_reg == 16'd2)
                        begin
                            slots_next[1] = rec;
                            tri_push      = 1'b1;
                            rotated       = (mode_reg == sfta_pkg::MODE_STRIP);
                        end
                        else if (mode_reg == sfta_pkg::MODE_STRIP)
                        begin
                            tri_push = 1'b1;
                            if (ordinal_reg[0])
                            begin
                                slots_next[0] = slots_reg[2];
                                slots_next[2] = rec;
                            end
                            else
                            begin
                                slots_next[0] = slots_reg[1];
                                slots_next[1] = rec;
                                rotated       = 1'b1;
                            end
                        end
                        else
                        begin
                            tri_push      = 1'b1;
                            slots_next[2] = slots_reg[1];
                            slots_next[1] = rec;
                        end
                        ordinal_next   = ordinal_reg + 16'd1;
                        remaining_next = remaining_reg - 16'd1;
                        if (remaining_next == '0)
                        begin
                            mode_next = sfta_pkg::MODE_HEADER;
                        end
                    end
                end
                default:
                begin
                    mode_next = sfta_pkg::MODE_HEADER;
                end
            endcase
        end
    end

    // Even strip triangles leave in slot order 1, 2, 0.
    always_comb
    begin
        if (rotated)
        begin
            tri_data[0] = slots_next[1];
            tri_data[1] = slots_next[2];
            tri_data[2] = slots_next[0];
        end
        else
        begin
            tri_data[0] = slots_next[0];
            tri_data[1] = slots_next[1];
            tri_data[2] = slots_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sfta_pkg::MODE_HEADER;
            remaining_reg <= '0;
            ordinal_reg   <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            ordinal_reg   <= ordinal_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (partial_we)
        begin
            partial_reg[pos_reg] <= word_u;
        end
        if (record_done)
        begin
            slots_reg <= slots_next;
        end
    end

endmodule

### rtl/core/sfta_queue.sv
// Two-entry triangle queue between the front and back parts.
module sfta_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sfta_pkg::triangle_t     push_data,
    input  logic                    pop,
    output sfta_pkg::triangle_t     pop_data,
    output sfta_pkg::queue_status_t status
);

    sfta_pkg::triangle_t mem_reg [0:sfta_pkg::QueueDepth-1];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == 2'(sfta_pkg::QueueDepth));
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/sfta_back.sv
// Back part: holds one triangle and hands out its three corners in order.
module sfta_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfta_pkg::queue_status_t q_status,
    input  sfta_pkg::triangle_t     q_data,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output sfta_pkg::corner_t       corner,
    output logic                    last_corner
);

    sfta_pkg::triangle_t tri_reg;
    logic                valid_reg, valid_next;
    logic [1:0]          corner_reg, corner_next;
    logic                taken;
    logic                finishing;

    assign empty       = !valid_reg;
    assign taken       = pop && valid_reg;
    assign last_corner = (corner_reg == sfta_pkg::CORNER_LAST);
    assign finishing   = taken && last_corner;
    assign q_pop       = !q_status.empty && (!valid_reg || finishing);
    assign corner      = tri_reg[corner_reg];

    always_comb
    begin
        valid_next  = valid_reg;
        corner_next = corner_reg;
        if (q_pop)
        begin
            valid_next  = 1'b1;
            corner_next = sfta_pkg::CORNER_FIRST;
        end
        else if (finishing)
        begin
            valid_next  = 1'b0;
            corner_next = sfta_pkg::CORNER_FIRST;
        end
        else if (taken)
        begin
            corner_next = corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            corner_reg <= sfta_pkg::CORNER_FIRST;
        end
        else
        begin
            valid_reg  <= valid_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tri_reg <= q_data;
        end
    end

endmodule

### tb/sv/triangle_corner_checker.sv
`timescale 1ns / 1ps
// Checker for the strip and fan triangle assembly block: predicts corners from accepted words.
module triangle_corner_checker
    import sfta_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic signed [WordWidth-1:0]  word,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [IndexWidth-1:0]        vertex_index,
    input  logic [IndexWidth-1:0]        normal_index,
    input  logic signed [WordWidth-1:0]  tex_s,
    input  logic signed [WordWidth-1:0]  tex_t,
    input  logic                         last_corner,
    output int                           mismatches,
    output int                           corners_pending
);

    typedef struct packed {
        corner_t corner;
        logic    last;
    } tagged_corner_t;

    tagged_corner_t corner_queue[$];

    logic [1:0]           list_mode;
    logic [15:0]          vertices_left;
    logic [15:0]          vertex_count;
    logic [1:0]           record_pos;
    logic [WordWidth-1:0] record_head [3];
    logic [WordWidth-1:0] slot_words [Corners][4];

    // Queues the three corners of the triangle held in the slots. When rotated,
    // corners leave in slot order 1, 2, 0.
    task automatic queue_triangle(input logic rotated);
        tagged_corner_t tc;
        int s;
        for (int i = 0; i < Corners; i++)
        begin
            s = rotated ? (i + 1) % Corners : i;
            tc.corner.vertex_index = slot_words[s][0][IndexWidth-1:0];
            tc.corner.normal_index = slot_words[s][1][IndexWidth-1:0];
            tc.corner.tex_s        = slot_words[s][2];
            tc.corner.tex_t        = slot_words[s][3];
            tc.last                = (i == Corners - 1);
            corner_queue.push_back(tc);
        end
    endtask

    task automatic put_slot(input int slot, input logic [WordWidth-1:0] w3);
        for (int j = 0; j < 3; j++)
        begin
            slot_words[slot][j] = record_head[j];
        end
        slot_words[slot][3] = w3;
    endtask

    // Advances the parser by one accepted word.
    task automatic assemble_word(input logic [WordWidth-1:0] w);
        if (list_mode == MODE_HEADER)
        begin
            if (w != '0)
            begin
                list_mode     = w[WordWidth-1] ? MODE_FAN : MODE_STRIP;
                vertices_left = w[WordWidth-1] ? 16'(-w) : w;
                vertex_count  = '0;
                record_pos    = '0;
            end
        end
        else if (record_pos != POS_LAST)
        begin
            record_head[record_pos] = w;
            record_pos++;
        end
        else
        begin
            record_pos = '0;
            if (vertex_count == 0)
            begin
                put_slot(0, w);
            end
            else if (vertex_count == 1)
            begin
                put_slot(2, w);
            end
            else if (vertex_count == 2)
            begin
                put_slot(1, w);
                queue_triangle(list_mode == MODE_STRIP);
            end
            else if (list_mode == MODE_STRIP && vertex_count[0])
            begin
                slot_words[0] = slot_words[2];
                put_slot(2, w);
                queue_triangle(1'b0);
            end
            else if (list_mode == MODE_STRIP)
            begin
                slot_words[0] = slot_words[1];
                put_slot(1, w);
                queue_triangle(1'b1);
            end
            else
            begin
                slot_words[2] = slot_words[1];
                put_slot(1, w);
                queue_triangle(1'b0);
            end
            vertex_count++;
            vertices_left--;
            if (vertices_left == 0)
            begin
                list_mode = MODE_HEADER;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tagged_corner_t want;
        tagged_corner_t got;
        if (!rst_n)
        begin
            list_mode     = MODE_HEADER;
            vertices_left = '0;
            vertex_count  = '0;
            record_pos    = '0;
            corner_queue.delete();
            mismatches    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.corner.vertex_index = vertex_index;
                got.corner.normal_index = normal_index;
                got.corner.tex_s        = tex_s;
                got.corner.tex_t        = tex_t;
                got.last                = last_corner;
                if (corner_queue.size() == 0)
                begin
                    $display("%0t: corner beat with none expected: vi=%h ni=%h s=%h t=%h last=%b",
                             $time, vertex_index, normal_index, tex_s, tex_t, last_corner);
                    mismatches++;
                end
                else
                begin
                    want = corner_queue.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: corner mismatch: expected vi=%h ni=%h s=%h t=%h last=%b",
                                 $time, want.corner.vertex_index, want.corner.normal_index,
                                 want.corner.tex_s, want.corner.tex_t, want.last);
                        $display("%0t:                  actual   vi=%h ni=%h s=%h t=%h last=%b",
                                 $time, vertex_index, normal_index, tex_s, tex_t, last_corner);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
            begin
                assemble_word(word);
            end
        end
        corners_pending = corner_queue.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the triangle assembly testbench: clock, reset, word stimulus and verdict.
module testbench;
    import sfta_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic signed [WordWidth-1:0] word;
    logic                        empty;
    logic                        pop;
    logic [IndexWidth-1:0]       vertex_index;
    logic [IndexWidth-1:0]       normal_index;
    logic signed [WordWidth-1:0] tex_s;
    logic signed [WordWidth-1:0] tex_t;
    logic                        last_corner;
    int                          mismatches;
    int                          corners_pending;

    int burst_left;
    int list_words;

    strip_fan_triangle_assembly_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .word         (word),
        .empty        (empty),
        .pop          (pop),
        .vertex_index (vertex_index),
        .normal_index (normal_index),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .last_corner  (last_corner)
    );

    triangle_corner_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .word            (word),
        .empty           (empty),
        .pop             (pop),
        .vertex_index    (vertex_index),
        .normal_index    (normal_index),
        .tex_s           (tex_s),
        .tex_t           (tex_t),
        .last_corner     (last_corner),
        .mismatches      (mismatches),
        .corners_pending (corners_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hands one word to the block and waits for its beat; the sender pauses
    // between bursts of random length.
    task automatic send_word(input logic [WordWidth-1:0] w);
        push <= 1'b1;
        word <= w;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_vertex(input logic [WordWidth-1:0] vi, input logic [WordWidth-1:0] ni,
                               input logic [WordWidth-1:0] s, input logic [WordWidth-1:0] t);
        send_word(vi);
        send_word(ni);
        send_word(s);
        send_word(t);
    endtask

    function automatic logic [WordWidth-1:0] random_word();
        logic [WordWidth-1:0] corner_values [4];
        corner_values = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        if ($urandom_range(0, 7) == 0)
        begin
            return corner_values[$urandom_range(0, 3)];
        end
        return WordWidth'($urandom_range(0, 65535));
    endfunction

    // Sends one header and its vertices with random content.
    task automatic send_list(input int count, input logic is_fan);
        send_word(is_fan ? WordWidth'(-count) : WordWidth'(count));
        for (int v = 0; v < count; v++)
        begin
            send_vertex(random_word(), random_word(), random_word(), random_word());
        end
        list_words += 1 + 4 * count;
    endtask

    // The receiver switches among four stall patterns, chosen at random.
    initial
    begin
        int pattern;
        int phase;
        pop     = 1'b0;
        pattern = 0;
        phase   = 0;
        forever
        begin
            @(negedge clk);
            if (phase == 0)
            begin
                pattern = $urandom_range(0, 3);
                phase   = $urandom_range(20, 80);
            end
            phase--;
            case (pattern)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                2: pop <= (phase % 4 == 0);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL strip_fan_triangle_assembly_core");
        $finish;
    end

    initial
    begin
        int r;
        rst_n      = 1'b0;
        push       = 1'b0;
        word       = '0;
        burst_left = 8;
        list_words = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: an empty list, a two-vertex strip that emits nothing, and a
        // three-vertex fan whose index words need masking to 15 bits.
        send_word(16'h0000);
        send_word(16'd2);
        send_vertex(16'h0001, 16'h0002, 16'h0003, 16'h0004);
        send_vertex(16'h0005, 16'h0006, 16'h0007, 16'h0008);
        send_word(16'hfffd);
        send_vertex(16'h8000, 16'hffff, 16'h7fff, 16'h8000);
        send_vertex(16'hffff, 16'h8000, 16'h0000, 16'hffff);
        send_vertex(16'h7fff, 16'h0000, 16'h8000, 16'h7fff);

        while (list_words < 420)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                send_word(16'h0000);
            end
            else if (r < 35)
            begin
                send_list($urandom_range(1, 12), 1'b1);
            end
            else if (r < 90)
            begin
                send_list($urandom_range(1, 12), 1'b0);
            end
            else
            begin
                send_list($urandom_range(13, 30), 1'b0);
            end
        end

        // The most negative header opens a fan far longer than the run; a few
        // of its vertices still form triangles.
        send_word(16'h8000);
        for (int v = 0; v < 6; v++)
        begin
            send_vertex(random_word(), random_word(), random_word(), random_word());
        end
        push <= 1'b0;

        @(negedge clk);
        while (corners_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("PASS strip_fan_triangle_assembly_core");
        end
        else
        begin
            $display("FAIL strip_fan_triangle_assembly_core");
        end
        $finish;
    end

endmodule
